@@ sv/lrwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lrwc_pkg;
  localparam int KEY_SLOTS_DEF  = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int WH_W = 64;
  localparam int WL_W = 56;
  localparam int OCC_W = 16;
  localparam int SLOT_W = 9;
  localparam int LETTERS = 26;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7a;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5a;
  localparam logic [1:0] REG_FIRST = 2'd0;
  localparam logic [1:0] REG_LAST  = 2'd1;
  localparam logic [1:0] REG_BASE  = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  // Classified request handed from front to back
  typedef struct packed {
    logic [WH_W-1:0] hi;
    logic [WL_W-1:0] lo;
    logic            keep;
    logic            eos;
  } req_t;
endpackage
`default_nettype wire

@@ sv/lrwc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lrwc_front import lrwc_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic [WH_W-1:0] word_high_i,
  input  wire logic [WL_W-1:0] word_low_i,
  input  wire logic            end_of_set_i,
  input  wire logic [4:0]      first_q_i,
  input  wire logic [4:0]      last_q_i,
  output logic                 req_valid_o,
  input  wire logic            req_pop_i,
  output req_t                 req_o
);
  // two-entry request queue
  req_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       cls;
  logic [7:0] ch;
  logic [4:0] idx;
  logic       letter, ended;

  // zero-pad normalization and letter check
  always_comb begin
    cls.hi = word_high_i;
    cls.lo = word_low_i;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (cls.hi[63-8*i -: 8] == 8'h00) ended = 1'b1;
      if (ended) cls.hi[63-8*i -: 8] = 8'h00;
    end
    for (int i = 0; i < 7; i++) begin
      if (cls.lo[55-8*i -: 8] == 8'h00) ended = 1'b1;
      if (ended) cls.lo[55-8*i -: 8] = 8'h00;
    end
    ch = cls.hi[63:56];
    letter = 1'b1;
    idx = '0;
    priority if (ch >= CH_LA && ch <= CH_LZ) idx = 5'(ch - CH_LA);
    else if (ch >= CH_UA && ch <= CH_UZ) idx = 5'(ch - CH_UA);
    else letter = 1'b0;
    cls.keep = letter && idx < 5'(LETTERS) && idx >= first_q_i && idx <= last_q_i;
    cls.eos = end_of_set_i;
  end

  assign busy_o      = cnt_q[1];
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) fifo_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (start_i && !busy_o) wp_q <= ~wp_q;
      if (req_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(start_i && !busy_o) - 2'(req_pop_i);
    end
  end
endmodule
`default_nettype wire

@@ sv/lrwc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lrwc_back import lrwc_pkg::*; #(
  parameter int KEY_SLOTS  = KEY_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_pop_o,
  input  wire req_t              req_i,
  input  wire logic [7:0]        base_q_i,
  input  wire logic [6:0]        scount_q_i,
  output logic                   res_valid_o,
  output logic [SLOT_W-1:0]      slot_o,
  output logic [WH_W-1:0]        key_high_o,
  output logic [WL_W-1:0]        key_low_o,
  output logic [OCC_W-1:0]       occurrences_o,
  output logic                   dropped_o,
  output logic                   final_res_o
);
  localparam int IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int NW = $clog2(KEY_SLOTS + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_CMP = 3'b010, S_EMIT = 3'b100
  } state_e;

  // sorted cell chain: each cell compares in parallel, insert shifts one step
  logic [WH_W-1:0]       kh_q [KEY_SLOTS];
  logic [WL_W-1:0]       kl_q [KEY_SLOTS];
  logic [COUNT_BITS-1:0] ct_q [KEY_SLOTS];
  logic [NW-1:0] used_q;
  logic          ovf_q;
  state_e        st_q;
  req_t          r_q;
  logic [KEY_SLOTS-1:0] gt_q, eq_q;
  logic [NW-1:0] er_q;
  logic [KEY_SLOTS-1:0] gt_c, eq_c;
  logic [IW-1:0] pos, hit;
  logic          anyeq;
  logic [6:0]    lastr;
  logic [NW-1:0] rank;

  // compare the queue head against every cell; captured on the pop edge
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      eq_c[i] = NW'(i) < used_q && {kh_q[i], kl_q[i]} == {req_i.hi, req_i.lo};
      gt_c[i] = NW'(i) < used_q && {kh_q[i], kl_q[i]} > {req_i.hi, req_i.lo};
    end
  end

  always_comb begin
    pos = IW'(used_q);
    hit = '0;
    anyeq = |eq_q;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (gt_q[i]) pos = IW'(i);
      if (eq_q[i]) hit = IW'(i);
    end
  end

  assign req_pop_o = st_q == S_IDLE && req_valid_i;
  assign lastr = (scount_q_i == 7'd0) ? 7'd0 : scount_q_i - 7'd1;
  assign rank  = ({1'b0, er_q} < {1'b0, NW'(lastr)} || 7'(er_q) < lastr) ? er_q : NW'(lastr);

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && req_valid_i) r_q <= req_i;
    gt_q <= gt_c;
    eq_q <= eq_c;
    if (st_q == S_CMP && r_q.keep) begin
      if (anyeq) begin
        if (ct_q[hit] != CMAX) ct_q[hit] <= ct_q[hit] + 1'b1;
      end else if (used_q < NW'(KEY_SLOTS)) begin
        for (int i = 1; i < KEY_SLOTS; i++)
          if (IW'(i) > pos) begin
            kh_q[i] <= kh_q[i-1]; kl_q[i] <= kl_q[i-1]; ct_q[i] <= ct_q[i-1];
          end
        kh_q[pos] <= r_q.hi; kl_q[pos] <= r_q.lo; ct_q[pos] <= COUNT_BITS'(1);
      end
    end
    if (st_q == S_EMIT) begin
      slot_o <= SLOT_W'(base_q_i) + SLOT_W'(rank);
      dropped_o <= ovf_q;
      final_res_o <= used_q == 0 || er_q + 1'b1 == used_q;
      if (used_q == 0) begin
        key_high_o <= '0; key_low_o <= '0; occurrences_o <= '0;
      end else begin
        key_high_o <= kh_q[er_q[IW-1:0]];
        key_low_o  <= kl_q[er_q[IW-1:0]];
        occurrences_o <= (32'(ct_q[er_q[IW-1:0]]) > 32'hFFFF) ? '1
                         : OCC_W'(ct_q[er_q[IW-1:0]]);
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; used_q <= '0; ovf_q <= 1'b0; er_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= st_q == S_EMIT;
      unique case (st_q)
        S_IDLE: if (req_valid_i) st_q <= S_CMP;
        S_CMP: begin
          if (r_q.keep && !anyeq) begin
            if (used_q < NW'(KEY_SLOTS)) used_q <= used_q + 1'b1;
            else ovf_q <= 1'b1;
          end
          er_q <= '0;
          st_q <= r_q.eos ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (used_q == 0 || er_q + 1'b1 == used_q) begin
            used_q <= '0; ovf_q <= 1'b0; st_q <= S_IDLE;
          end
          er_q <= er_q + 1'b1;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/letter_range_word_counter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An end_of_set request's results follow its S_CMP and S_EMIT states (registered).
// Per request: compare on the pop, then update of the cell chain in S_CMP; the next
// is taken in S_IDLE, after S_EMIT emits one result per distinct word on end_of_set.
// A two-entry queue parts classification from the table; results cannot be stalled.
// Reset clears the table fill count, overflow flag and control registers; no clearing pass.
module letter_range_word_counter_unit import lrwc_pkg::*; #(
  parameter int KEY_SLOTS  = KEY_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [WH_W-1:0]   word_high_i,
  input  wire logic [WL_W-1:0]   word_low_i,
  input  wire logic              end_of_set_i,
  output logic                   strobe,
  output logic [SLOT_W-1:0]      slot_o,
  output logic [WH_W-1:0]        key_high_o,
  output logic [WL_W-1:0]        key_low_o,
  output logic [OCC_W-1:0]       occurrences_o,
  output logic                   dropped_o,
  output logic                   final_res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  logic [4:0] first_q, last_q;
  logic [7:0] base_q;
  logic [6:0] scount_q;
  logic       rv, pop;
  req_t       rq;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 5'd0; last_q <= 5'd13; base_q <= 8'd0; scount_q <= 7'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_FIRST: first_q  <= pwdata[4:0];
        REG_LAST:  last_q   <= pwdata[4:0];
        REG_BASE:  base_q   <= pwdata[7:0];
        REG_COUNT: scount_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FIRST: prdata = {27'd0, first_q};
      REG_LAST:  prdata = {27'd0, last_q};
      REG_BASE:  prdata = {24'd0, base_q};
      REG_COUNT: prdata = {25'd0, scount_q};
      default:   prdata = '0;
    endcase
  end

  lrwc_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .word_high_i, .word_low_i, .end_of_set_i,
    .first_q_i(first_q), .last_q_i(last_q),
    .req_valid_o(rv), .req_pop_i(pop), .req_o(rq)
  );

  lrwc_back #(.KEY_SLOTS(KEY_SLOTS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .req_valid_i(rv), .req_pop_o(pop), .req_i(rq),
    .base_q_i(base_q), .scount_q_i(scount_q),
    .res_valid_o(strobe), .slot_o, .key_high_o, .key_low_o,
    .occurrences_o, .dropped_o, .final_res_o
  );
endmodule
`default_nettype wire

@@ sim/letter_range_word_counter_unit_tb.sv @@
`timescale 1ns / 1ps
module letter_range_word_counter_unit_tb;
  import lrwc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [WH_W-1:0]   kh;
    logic [WL_W-1:0]   kl;
    logic [OCC_W-1:0]  occ;
    logic              dropped;
    logic              fin;
  } tally_t;

  // Word tally predictor and expected-result store
  class word_tally_board;
    logic [4:0]   first_letter = 5'd0;
    logic [4:0]   last_letter  = 5'd13;
    logic [7:0]   slot_base    = 8'd0;
    logic [6:0]   slot_count   = 7'd64;
    logic [119:0] keys[$];
    int           counts[$];
    bit           overflow;
    tally_t       pending_tallies[$];
    int           mismatches;
    int           words_seen;
    int           sets_seen;
    int           tallies_checked;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_FIRST: first_letter = val[4:0];
        REG_LAST:  last_letter  = val[4:0];
        REG_BASE:  slot_base    = val[7:0];
        REG_COUNT: slot_count   = val[6:0];
        default: ;
      endcase
    endfunction

    // Zero every byte from the first zero byte on
    function logic [119:0] trim(logic [119:0] w);
      bit ended;
      ended = 0;
      for (int i = 0; i < 15; i++) begin
        if (ended || w[119-8*i -: 8] == 8'h00) begin
          ended = 1;
          w[119-8*i -: 8] = 8'h00;
        end
      end
      return w;
    endfunction

    function bit in_range(logic [7:0] ch);
      int idx;
      if (ch >= CH_LA && ch <= CH_LZ) idx = ch - CH_LA;
      else if (ch >= CH_UA && ch <= CH_UZ) idx = ch - CH_UA;
      else return 0;
      return idx >= first_letter && idx <= last_letter;
    endfunction

    function void note_word(logic [WH_W-1:0] hi, logic [WL_W-1:0] lo, logic eos);
      logic [119:0] w;
      int p;
      int last_rank;
      tally_t t;
      words_seen++;
      w = trim({hi, lo});
      if (in_range(w[119:112])) begin
        p = 0;
        while (p < keys.size() && keys[p] < w) p++;
        if (p < keys.size() && keys[p] == w) begin
          if (counts[p] < COUNT_MAX) counts[p]++;
        end else if (keys.size() >= KEY_SLOTS_DEF) begin
          overflow = 1;
        end else begin
          keys.insert(p, w);
          counts.insert(p, 1);
        end
      end
      if (!eos) return;
      sets_seen++;
      last_rank = (slot_count == 0) ? 0 : slot_count - 1;
      if (keys.size() == 0) begin
        t.slot = {1'b0, slot_base}; t.kh = '0; t.kl = '0; t.occ = '0;
        t.dropped = overflow; t.fin = 1;
        pending_tallies.push_back(t);
      end
      for (int r = 0; r < keys.size(); r++) begin
        t.slot = SLOT_W'(slot_base + ((r < last_rank) ? r : last_rank));
        t.kh = keys[r][119:56];
        t.kl = keys[r][55:0];
        t.occ = (counts[r] > 65535) ? 16'hffff : OCC_W'(counts[r]);
        t.dropped = overflow;
        t.fin = (r == keys.size() - 1);
        pending_tallies.push_back(t);
      end
      keys.delete();
      counts.delete();
      overflow = 0;
    endfunction

    function void check_tally(tally_t got);
      tally_t want;
      if (pending_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result slot %0d key %h_%h occ %0d",
                   got.slot, got.kh, got.kl, got.occ);
        return;
      end
      want = pending_tallies.pop_front();
      tallies_checked++;
      if (got.slot !== want.slot || got.kh !== want.kh || got.kl !== want.kl ||
          got.occ !== want.occ || got.dropped !== want.dropped || got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp slot %0d key %h_%h occ %0d drop %b fin %b / got slot %0d key %h_%h occ %0d drop %b fin %b",
                   want.slot, want.kh, want.kl, want.occ, want.dropped, want.fin,
                   got.slot, got.kh, got.kl, got.occ, got.dropped, got.fin);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic start, busy;
  logic [WH_W-1:0] word_high_i;
  logic [WL_W-1:0] word_low_i;
  logic end_of_set_i;
  logic strobe;
  logic [SLOT_W-1:0] slot_o;
  logic [WH_W-1:0] key_high_o;
  logic [WL_W-1:0] key_low_o;
  logic [OCC_W-1:0] occurrences_o;
  logic dropped_o, final_res_o;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  word_tally_board board = new();
  int burst_left;
  bit no_gaps;
  int cycle_count = 0;

  letter_range_word_counter_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .word_high_i(word_high_i), .word_low_i(word_low_i), .end_of_set_i(end_of_set_i),
    .strobe(strobe), .slot_o(slot_o), .key_high_o(key_high_o), .key_low_o(key_low_o),
    .occurrences_o(occurrences_o), .dropped_o(dropped_o), .final_res_o(final_res_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Result monitor
  always @(posedge clk_i) begin
    tally_t got;
    if (rst_ni && strobe) begin
      got.slot = slot_o; got.kh = key_high_o; got.kl = key_low_o;
      got.occ = occurrences_o; got.dropped = dropped_o; got.fin = final_res_o;
      board.check_tally(got);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL letter_range_word_counter_unit");
      $finish;
    end
  end

  // One request, sent in bursts with random gaps (none when no_gaps is set)
  task automatic send_word(logic [119:0] w, logic eos);
    if (burst_left == 0) begin
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    word_high_i <= w[119:56];
    word_low_i <= w[55:0];
    end_of_set_i <= eos;
    do @(posedge clk_i); while (busy);
    board.note_word(w[119:56], w[55:0], eos);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_tallies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic set_config(int fl, int ll, int base, int cnt);
    cfg_write(REG_FIRST, fl);
    cfg_write(REG_LAST, ll);
    cfg_write(REG_BASE, base);
    cfg_write(REG_COUNT, cnt);
  endtask

  // Word of len bytes starting with the given letter; tail from a small alphabet
  function automatic logic [119:0] make_word(int letter, bit upper, int len);
    logic [119:0] w;
    w = '0;
    w[119:112] = 8'((upper ? CH_UA : CH_LA) + letter);
    for (int i = 1; i < len; i++) w[119-8*i -: 8] = 8'(CH_LA + $urandom_range(0, 2));
    return w;
  endfunction

  function automatic logic [119:0] noise_word();
    logic [127:0] n;
    n = {$urandom, $urandom, $urandom, $urandom};
    return n[119:0];
  endfunction

  initial begin
    logic [119:0] w;
    int set_len, fl, ll;
    rst_ni = 0; start = 0; word_high_i = '0; word_low_i = '0; end_of_set_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    burst_left = 0; no_gaps = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset config, case mix, repeats, range edges, garbage after zero
    send_word(make_word(0, 0, 1), 0);
    send_word(make_word(0, 1, 1), 0);
    send_word(make_word(13, 0, 15), 0);
    send_word(make_word(14, 0, 3), 0);
    send_word({8'h61, 8'h00, {13{8'hff}}}, 0);
    send_word({8'h62, {14{8'hff}}}, 0);
    send_word({8'h40, {14{8'h41}}}, 0);
    send_word({8'h5b, {14{8'h61}}}, 0);
    send_word({120{1'b1}}, 0);
    send_word('0, 0);
    send_word(make_word(0, 1, 1), 1);
    // Set with nothing kept
    send_word(make_word(20, 0, 2), 1);
    drain();

    // Empty range
    set_config(20, 5, 255, 1);
    send_word(make_word(3, 0, 2), 0);
    send_word(make_word(25, 1, 2), 1);
    drain();
    // Full range, last_letter above 25, zero slot_count
    set_config(0, 31, 200, 0);
    send_word(make_word(25, 0, 4), 0);
    send_word(make_word(25, 1, 4), 0);
    send_word(make_word(12, 0, 4), 1);
    drain();
    set_config(0, 25, 17, 3);
    send_word(make_word(1, 0, 2), 0);
    send_word(make_word(2, 0, 2), 0);
    send_word(make_word(3, 0, 2), 0);
    send_word(make_word(4, 0, 2), 0);
    send_word(make_word(5, 0, 2), 1);
    drain();

    // Table overflow: more distinct words than entries
    set_config(0, 25, 128, 127);
    for (int i = 0; i < 80; i++) begin
      w = '0;
      w[119:112] = 8'(CH_LA + (i % 26));
      w[111:104] = 8'(CH_LA + (i / 26));
      w[103:96]  = 8'(CH_LA + $urandom_range(0, 1));
      send_word(w, i == 79);
    end
    drain();

    // Random sets under several settings
    for (int phase = 0; phase < 8; phase++) begin
      fl = $urandom_range(0, 12);
      ll = $urandom_range(fl, 25);
      if (phase == 7) begin fl = 0; ll = 25; end
      set_config(fl, ll, $urandom_range(0, 255), $urandom_range(1, 64));
      no_gaps = (phase % 3 == 2);
      for (int s = 0; s < 8; s++) begin
        set_len = $urandom_range(1, 10);
        for (int k = 0; k < set_len; k++) begin
          case ($urandom_range(0, 9))
            0: w = noise_word();
            1: w = make_word($urandom_range(0, 25), 1'($urandom_range(0, 1)),
                             $urandom_range(1, 15));
            default: w = make_word($urandom_range(fl, ll), 1'($urandom_range(0, 1)),
                                   $urandom_range(1, 3));
          endcase
          if ($urandom_range(0, 7) == 0) w[55:0] = 56'({$urandom, $urandom});
          send_word(w, k == set_len - 1);
        end
      end
      drain();
    end

    $display("Covered %0d words in %0d sets, %0d results checked,", board.words_seen,
             board.sets_seen, board.tallies_checked);
    $display("including overflow, slot clamping and empty ranges.");
    if (board.mismatches == 0 && board.pending_tallies.size() == 0) begin
      $display("PASS letter_range_word_counter_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_tallies.size());
      $display("FAIL letter_range_word_counter_unit");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/lrwc_pkg.sv
sv/lrwc_front.sv
sv/lrwc_back.sv
sv/letter_range_word_counter_unit.sv
sim/letter_range_word_counter_unit_tb.sv
